/* design/indexed_ordered_list_top_defines.svh */
// Assertion macros shared by the ordered list engine.
`ifndef INDEXED_ORDERED_LIST_TOP_DEFINES_SVH
`define INDEXED_ORDERED_LIST_TOP_DEFINES_SVH

// Checked on every rising edge once reset has been released.
`define IOL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, during reset too.
`define IOL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/iol_pkg.sv */
// Package with the types, codes and widths of the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int ITEM_W   = 32;
  localparam int FPOS_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 9;
  localparam int WIDE_W   = 64;

  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_WAIT,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_SHIFT,
    S_FIND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* design/indexed_ordered_list_top.sv */
// Top level of the ordered list engine: sequencer and entry memory.
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_stall_o  op_i, position_i, item_value_i
//   out      output     out_valid_o / out_stall_i read_value_o, found_o,
//                                                found_position_o, status_o, entry_count_o
//
// One word is worked on at a time; the entry memory gives one read and one write a cycle.
// Get waits for read data; set, clear, rejected and unused requests go straight to done.
// Insert and remove shift the entries behind the position, one shift a cycle.
// Find compares the entries in order, one comparison a cycle, up to the first match.
// Reset clears the count and the control state only; the memory needs no clearing pass.
// A stalled result word holds in the output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module indexed_ordered_list_top
  import iol_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [ITEM_W-1:0]   item_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [ITEM_W-1:0]   read_value_o,
  output logic                     found_o,
  output logic      [FPOS_W-1:0]   found_position_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [CNT_W-1:0]    entry_count_o
);

  localparam int AW = $clog2(CAPACITY);

  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          mem_raddr;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  iol_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_value_o     (read_value_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .mem_ctl_o        (mem_ctl),
    .mem_raddr_o      (mem_raddr),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata)
  );

  iol_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .raddr_i   (mem_raddr),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .rdata_o   (mem_rdata)
  );

endmodule

`default_nettype wire

/* design/iol_mem.sv */
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module iol_mem
  import iol_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = VALUE_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire mem_ctl_t         mem_ctl_i,
  input  wire logic [AW-1:0]    raddr_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/iol_ctrl.sv */
// Sequencer that reads, shifts and searches the entry memory and holds the result word.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_ordered_list_top_defines.svh"

module iol_ctrl
  import iol_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [OP_W-1:0]        op_i,
  input  wire logic [POS_W-1:0]       position_i,
  input  wire logic [ITEM_W-1:0]      item_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [ITEM_W-1:0]      read_value_o,
  output logic                        found_o,
  output logic      [FPOS_W-1:0]      found_position_o,
  output logic      [STATUS_W-1:0]    status_o,
  output logic      [CNT_W-1:0]       entry_count_o,
  output mem_ctl_t                    mem_ctl_o,
  output logic      [AW-1:0]          mem_raddr_o,
  output logic      [AW-1:0]          mem_waddr_o,
  output logic      [VALUE_WIDTH-1:0] mem_wdata_o,
  input  wire logic [VALUE_WIDTH-1:0] mem_rdata_i
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_e state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_addr_q, pend_addr_d;
  logic                   first_q, first_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;
  logic                   fnd_q, fnd_d;
  logic [AW-1:0]          fpos_q, fpos_d;
  logic [STATUS_W-1:0]    st_q, st_d;

  logic                   out_valid_q, out_valid_d;
  logic [ITEM_W-1:0]      out_rd_q;
  logic                   out_fnd_q;
  logic [FPOS_W-1:0]      out_fpos_q;
  logic [STATUS_W-1:0]    out_st_q;
  logic [CNT_W-1:0]       out_cnt_q;
  logic                   load_out;

  logic [PW-1:0]          pos_ext;
  logic [PW-1:0]          cnt_ext;
  logic                   pos_lt_cnt;
  logic                   pos_le_cnt;
  logic [CW-1:0]          pos_cw;
  logic [WIDE_W-1:0]      item_wide;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [CW-1:0]          idx_m1;
  logic [WIDE_W-1:0]      rd_wide;
  logic [WIDE_W-1:0]      fpos_wide;
  logic [WIDE_W-1:0]      cnt_wide;

  assign pos_ext    = PW'(position_i);
  assign cnt_ext    = PW'(count_q);
  assign pos_lt_cnt = pos_ext < cnt_ext;
  assign pos_le_cnt = pos_ext <= cnt_ext;
  assign pos_cw     = CW'(position_i);
  assign item_wide  = {{(WIDE_W - ITEM_W){1'b0}}, item_value_i};
  assign val_in     = item_wide[VALUE_WIDTH-1:0];
  assign idx_m1     = idx_q - CW'(1);
  assign rd_wide    = WIDE_W'(rd_q);
  assign fpos_wide  = WIDE_W'(fpos_q);
  assign cnt_wide   = WIDE_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    pend_addr_q <= pend_addr_d;
    rd_q        <= rd_d;
    fnd_q       <= fnd_d;
    fpos_q      <= fpos_d;
    st_q        <= st_d;
    if (load_out) begin
      out_rd_q   <= rd_wide[ITEM_W-1:0];
      out_fnd_q  <= fnd_q;
      out_fpos_q <= fpos_wide[FPOS_W-1:0];
      out_st_q   <= st_q;
      out_cnt_q  <= cnt_wide[CNT_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    val_d       = val_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    first_d     = first_q;
    rd_d        = rd_q;
    fnd_d       = fnd_q;
    fpos_d      = fpos_q;
    st_d        = st_q;
    load_out    = 1'b0;
    mem_ctl_o   = '0;
    mem_raddr_o = idx_q[AW-1:0];
    mem_waddr_o = pend_addr_q;
    mem_wdata_o = mem_rdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rd_d    = '0;
          fnd_d   = 1'b0;
          fpos_d  = '0;
          st_d    = ST_OK;
          pos_d   = pos_cw;
          val_d   = val_in;
          pend_d  = 1'b0;
          first_d = 1'b0;
          state_d = S_DONE;
          unique case (op_i)
            OP_GET: begin
              if (pos_lt_cnt) begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = pos_cw[AW-1:0];
                state_d         = S_GET_WAIT;
              end else begin
                st_d = ST_RANGE;
              end
            end
            OP_SET: begin
              if (pos_lt_cnt) begin
                mem_ctl_o.wr_en = 1'b1;
                mem_waddr_o     = pos_cw[AW-1:0];
                mem_wdata_o     = val_in;
              end else begin
                st_d = ST_RANGE;
              end
            end
            OP_INSERT: begin
              if (!pos_le_cnt) begin
                st_d = ST_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                idx_d   = count_q;
                state_d = S_INS_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (pos_lt_cnt) begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = pos_cw[AW-1:0];
                idx_d           = pos_cw + CW'(1);
                first_d         = 1'b1;
                state_d         = S_REM_SHIFT;
              end else begin
                st_d = ST_RANGE;
              end
            end
            OP_FIND: begin
              idx_d   = '0;
              state_d = S_FIND;
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        rd_d    = mem_rdata_i;
        state_d = S_DONE;
      end
      S_INS_SHIFT: begin
        if (pend_q) begin
          mem_ctl_o.wr_en = 1'b1;
        end
        if (idx_q > pos_q) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = idx_m1[AW-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_q[AW-1:0];
          idx_d           = idx_m1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = pos_q[AW-1:0];
        mem_wdata_o     = val_q;
        count_d         = count_q + CW'(1);
        state_d         = S_DONE;
      end
      S_REM_SHIFT: begin
        if (first_q) begin
          rd_d    = mem_rdata_i;
          first_d = 1'b0;
        end
        if (pend_q) begin
          mem_ctl_o.wr_en = 1'b1;
        end
        if (idx_q < count_q) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = idx_q[AW-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_m1[AW-1:0];
          idx_d           = idx_q + CW'(1);
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_FIND: begin
        if (pend_q && (mem_rdata_i == val_q)) begin
          fnd_d   = 1'b1;
          fpos_d  = pend_addr_q;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (idx_q < count_q) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = idx_q[AW-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_q[AW-1:0];
          idx_d           = idx_q + CW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign read_value_o     = out_rd_q;
  assign found_o          = out_fnd_q;
  assign found_position_o = out_fpos_q;
  assign status_o         = out_st_q;
  assign entry_count_o    = out_cnt_q;

  `IOL_ASSERT(a_count_bound, (count_q <= CW'(CAPACITY)), "entry count beyond capacity")
  `IOL_ASSERT(a_no_rw_clash, ((mem_ctl_o.rd_en && mem_ctl_o.wr_en) |-> (mem_raddr_o != mem_waddr_o)), "read and write hit the same entry")
  `IOL_ASSERT(a_write_in_list, (mem_ctl_o.wr_en |-> (CW'(mem_waddr_o) <= count_q)), "write beyond the end of the list")
  `IOL_ASSERT(a_find_keeps_count, ((state_q == S_FIND) |=> $stable(count_q)), "search changed the entry count")
  `IOL_ASSERT(a_idle_holds, ((state_q == S_IDLE && !in_valid_i) |=> (state_q == S_IDLE)), "left idle without a word")

endmodule

`default_nettype wire
